// ===== rtl/lfpr_pkg.sv =====
`default_nettype none
package lfpr_pkg;

  localparam int MAX_SAMPLES = 8192;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int WINDOW      = 4;

  // divider operand widths: numerator (t - tj) * 2^16, denominator ti - tj
  localparam int NUM_W = 49;
  localparam int DEN_W = 33;
  localparam int NMAG_W = NUM_W - 1;
  localparam int DMAG_W = DEN_W - 1;
  localparam int DIV_CNT_W = $clog2(NMAG_W);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOWINDOW = 2'd3;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TIME,
    S_CHECK,
    S_LO,
    S_HI,
    S_SA,
    S_SB,
    S_SC,
    S_WIN,
    S_EQ,
    S_DIVST,
    S_DIVW,
    S_MUL,
    S_NEXTJ,
    S_TERM,
    S_SUM,
    S_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lagrange_four_point_resampler_unit.sv =====
`default_nettype none
// Four-point Lagrange resampler over a stored trace.
// Input channel (in_valid / in_stall) carries requests: load appends a
// (time, value) sample, clear empties the trace, query asks for output k.
// Loads, clears and unused codes give no result; loads beyond 8192
// samples are dropped.
// A query returns one result on the output channel (out_valid / out_stall):
// new_time = origin_time + k * new_step, new_value interpolated, and status.
// An interpolating query picks its window, by a forward search where
// needed, then forms each ratio on the shared restoring divider (48
// iterations per ratio), each followed by its multiply; a query rejected
// on sample count or index skips the search and the divides.
// in_stall stays high while a query is in work; one request at a time.
// A finished result sits in the output register; a new request is taken
// while it waits, but the next query holds in its final state until the
// receiver takes the pending result.
// Config writes (cfg_write, cfg_index, cfg_data) must go in while idle; the block itself does not enforce this.
// Reset clears the sample count, the search cursor and the config registers to
// their defaults; the trace memories hold no defined reset contents.
module lagrange_four_point_resampler_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] sample_time,
  input  wire logic signed [31:0] sample_value,
  input  wire logic [15:0]        query_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      new_time,
  output logic signed [31:0]      new_value,
  output logic [1:0]              status
);
  import lfpr_pkg::*;

  logic signed [31:0] origin_time;
  logic [30:0]        new_step;
  logic [15:0]        output_count;

  logic signed [31:0] time_mem  [MAX_SAMPLES];
  logic signed [31:0] value_mem [MAX_SAMPLES];
  logic signed [31:0] rt;
  logic signed [31:0] rv;
  logic [ADDR_W-1:0]  rd_addr;

  logic [COUNT_W-1:0] sample_count;
  logic [ADDR_W-1:0]  search_cursor;

  state_t state, state_next;

  logic [15:0]        k;
  logic signed [31:0] t;
  logic signed [31:0] val;
  logic [1:0]         st;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  base;
  logic               ge_lo;
  logic [2:0]         wc;
  logic signed [31:0] tw [WINDOW];
  logic signed [31:0] vw [WINDOW];
  logic [1:0]         ii;
  logic [1:0]         jj;
  logic signed [31:0] basis;
  logic signed [31:0] ratio;
  logic signed [49:0] sum;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic signed [32:0] xdiff;

  logic [46:0]        kstep;
  logic signed [48:0] tsum;
  logic signed [63:0] bprod;
  logic signed [63:0] vprod;
  logic               any_equal;
  logic               cand_end;

  assign accept = in_valid && !in_stall;

  assign kstep = k * new_step;
  assign tsum  = {{17{origin_time[31]}}, origin_time} + $signed({2'b00, kstep});
  assign bprod = basis * ratio;
  assign vprod = vw[ii] * basis;
  assign xdiff = {t[31], t} - {tw[jj][31], tw[jj]};
  assign div_num = {xdiff, 16'b0};
  assign div_den = {tw[ii][31], tw[ii]} - {tw[jj][31], tw[jj]};
  assign cand_end = ({2'b00, idx} + (ADDR_W + 2)'(3)) >= {1'b0, sample_count};
  assign any_equal = (tw[0] == tw[1]) || (tw[0] == tw[2]) || (tw[0] == tw[3]) ||
                     (tw[1] == tw[2]) || (tw[1] == tw[3]) || (tw[2] == tw[3]);

  lfpr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_time  <= '0;
      new_step     <= 31'd65536;
      output_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START: origin_time  <= cfg_data;
        CFG_STEP:  new_step     <= cfg_data[30:0];
        CFG_COUNT: output_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD && !sample_count[COUNT_W-1]) begin
      time_mem[sample_count[ADDR_W-1:0]]  <= sample_time;
      value_mem[sample_count[ADDR_W-1:0]] <= sample_value;
    end
    rt <= time_mem[rd_addr];
    rv <= value_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && req_type == REQ_QUERY) state_next = S_TIME;
      S_TIME:  state_next = S_CHECK;
      S_CHECK: begin
        if (sample_count < COUNT_W'(WINDOW) || k >= output_count) begin
          state_next = S_FIN;
        end else begin
          state_next = S_LO;
        end
      end
      S_LO:    state_next = (t < rt) ? S_WIN : S_HI;
      S_HI:    state_next = (t > rt) ? S_WIN : S_SA;
      S_SA:    state_next = cand_end ? S_FIN : S_SB;
      S_SB:    state_next = S_SC;
      S_SC:    state_next = (ge_lo && t <= rt) ? S_WIN : S_SA;
      S_WIN:   if (wc == 3'd4) state_next = S_EQ;
      S_EQ:    state_next = any_equal ? S_FIN : S_DIVST;
      S_DIVST: state_next = (jj == ii) ? S_NEXTJ : S_DIVW;
      S_DIVW:  if (div_done) state_next = S_MUL;
      S_MUL:   state_next = S_NEXTJ;
      S_NEXTJ: state_next = (jj == 2'd3) ? S_TERM : S_DIVST;
      S_TERM:  state_next = (ii == 2'd3) ? S_SUM : S_DIVST;
      S_SUM:   state_next = S_FIN;
      S_FIN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_DIVST) && (jj != ii);
    unique case (state)
      S_CHECK: rd_addr = ADDR_W'(1);
      S_LO:    rd_addr = sample_count[ADDR_W-1:0] - ADDR_W'(2);
      S_SA:    rd_addr = idx + ADDR_W'(1);
      S_SB:    rd_addr = idx + ADDR_W'(2);
      S_WIN:   rd_addr = base + ADDR_W'(wc[1:0]);
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_count  <= '0;
      search_cursor <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (req_type == REQ_LOAD && !sample_count[COUNT_W-1]) begin
          sample_count <= sample_count + 1'b1;
        end else if (req_type == REQ_CLEAR) begin
          sample_count  <= '0;
          search_cursor <= '0;
        end
      end
      if (state == S_SC && ge_lo && t <= rt) search_cursor <= idx;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:  k <= query_index;
      S_TIME:  t <= sat32({tsum[48], tsum});
      S_CHECK: begin
        val <= '0;
        if (sample_count < COUNT_W'(WINDOW)) begin
          st <= ST_FEW;
        end else if (k >= output_count) begin
          st <= ST_RANGE;
        end else begin
          st <= ST_OK;
        end
      end
      S_LO: begin
        base <= '0;
        wc   <= '0;
      end
      S_HI: begin
        base <= sample_count[ADDR_W-1:0] - ADDR_W'(WINDOW);
        idx  <= search_cursor;
      end
      S_SA:    if (cand_end) st <= ST_NOWINDOW;
      S_SB:    ge_lo <= (t >= rt);
      S_SC: begin
        if (ge_lo && t <= rt) begin
          base <= idx;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_WIN: begin
        wc <= wc + 1'b1;
        if (wc != 3'd0) begin
          tw[wc[1:0] - 2'd1] <= rt;
          vw[wc[1:0] - 2'd1] <= rv;
        end
      end
      S_EQ: begin
        if (any_equal) st <= ST_NOWINDOW;
        ii    <= '0;
        jj    <= '0;
        basis <= ONE_Q16;
        sum   <= '0;
      end
      S_DIVW:  if (div_done) ratio <= div_quo;
      // floor by arithmetic shift, then saturate
      S_MUL:   basis <= sat32({{2{bprod[63]}}, bprod[63:16]});
      S_NEXTJ: jj <= jj + 1'b1;
      S_TERM: begin
        sum   <= sum + {{2{vprod[63]}}, vprod[63:16]};
        ii    <= ii + 1'b1;
        jj    <= '0;
        basis <= ONE_Q16;
      end
      S_SUM:   val <= sat32(sum);
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          new_time  <= t;
          new_value <= val;
          status    <= st;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lfpr_div.sv =====
`default_nettype none
module lfpr_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [lfpr_pkg::NUM_W-1:0] num,
  input  wire logic signed [lfpr_pkg::DEN_W-1:0] den,
  output logic                                  done,
  output logic signed [31:0]                    quo
);
  import lfpr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DMAG_W:0]      rem;
  logic [NMAG_W-1:0]    dq;
  logic [DMAG_W-1:0]    dmag;
  logic                 qneg;

  logic [NUM_W-1:0]  nabs;
  logic [DEN_W-1:0]  dabs;
  logic [DMAG_W:0]   shifted;
  logic              ge;

  assign nabs    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dabs    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign shifted = {rem[DMAG_W-1:0], dq[NMAG_W-1]};
  assign ge      = shifted >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NMAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dq   <= nabs[NMAG_W-1:0];
      dmag <= dabs[DMAG_W-1:0];
      qneg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy) begin
      rem <= ge ? shifted - {1'b0, dmag} : shifted;
      dq  <= {dq[NMAG_W-2:0], ge};
    end
  end

  // truncate toward zero, then saturate
  always_comb begin
    if (qneg) begin
      quo = sat32(-$signed({2'b00, dq}));
    end else begin
      quo = sat32($signed({2'b00, dq}));
    end
  end

endmodule
`default_nettype wire

// ===== tb/lagrange_four_point_resampler_unit_test.sv =====
`default_nettype none
module lagrange_four_point_resampler_unit_test;
  import lfpr_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int LOAD_DRAIN = 8;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] v;
    logic [1:0]         st;
  } resample_t;

  class resample_scoreboard;
    int           times [MAX_SAMPLES];
    int           values [MAX_SAMPLES];
    int unsigned  count;
    int unsigned  cursor;
    int           start_t;
    int unsigned  step;
    int unsigned  out_count;
    resample_t    pending_q[$];
    int           errors;
    int           queries;
    int           loads;
    int           status_seen [4];

    function new();
      count = 0;
      cursor = 0;
      start_t = 0;
      step = 65536;
      out_count = 0;
      errors = 0;
      queries = 0;
      loads = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        CFG_START: start_t = d;
        CFG_STEP:  step = 32'(d[30:0]);
        CFG_COUNT: out_count = 32'(d[15:0]);
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint lagrange_at(longint x, int unsigned b);
      longint sum, basis, ti, tj, r;
      sum = 0;
      for (int i = 0; i < WINDOW; i++) begin
        basis = 65536;
        ti = times[b + i];
        for (int j = 0; j < WINDOW; j++) begin
          if (j != i) begin
            tj = times[b + j];
            r = clip32(((x - tj) * 65536) / (ti - tj));
            basis = clip32((basis * r) >>> 16);
          end
        end
        sum += (longint'(values[b + i]) * basis) >>> 16;
      end
      return clip32(sum);
    endfunction

    function void note(logic [1:0] rt, int st, int sv, logic [15:0] k);
      longint      t;
      resample_t   e;
      int unsigned b;
      bit          found, dup;
      case (rt)
        REQ_LOAD: begin
          loads++;
          if (count < MAX_SAMPLES) begin
            times[count] = st;
            values[count] = sv;
            count++;
          end
        end
        REQ_CLEAR: begin
          count = 0;
          cursor = 0;
        end
        REQ_QUERY: begin
          queries++;
          t = clip32(longint'(start_t) + longint'(k) * longint'(step));
          e.t = 32'(t);
          e.v = 0;
          e.st = ST_OK;
          if (count < WINDOW) e.st = ST_FEW;
          else if (k >= out_count) e.st = ST_RANGE;
          else begin
            b = 0;
            found = 1;
            if (t < times[1]) b = 0;
            else if (t > times[count - 2]) b = count - WINDOW;
            else begin
              found = 0;
              for (int unsigned i = cursor; i + 3 < count; i++) begin
                if (t >= times[i + 1] && t <= times[i + 2]) begin
                  b = i;
                  found = 1;
                  break;
                end
              end
              if (found) cursor = b;
            end
            dup = 0;
            if (found)
              for (int i = 0; i < WINDOW; i++)
                for (int j = i + 1; j < WINDOW; j++)
                  if (times[b + i] == times[b + j]) dup = 1;
            if (!found || dup) e.st = ST_NOWINDOW;
            else e.v = 32'(lagrange_at(t, b));
          end
          status_seen[e.st]++;
          pending_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check(resample_t got);
      resample_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result t=%0d v=%0d st=%0d", got.t, got.v, got.st);
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected t=%0d v=%0d st=%0d, got t=%0d v=%0d st=%0d",
                   e.t, e.v, e.st, got.t, got.v, got.st);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [1:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         req_type = 0;
  logic signed [31:0] sample_time = 0;
  logic signed [31:0] sample_value = 0;
  logic [15:0]        query_index = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] new_time;
  logic signed [31:0] new_value;
  logic [1:0]         status;

  resample_scoreboard sb = new();
  int idle_cycles = 0;

  lagrange_four_point_resampler_unit dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note(req_type, sample_time, sample_value, query_index);
      if (out_valid && !out_stall) sb.check('{new_time, new_value, status});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
  endfunction

  // receiver: hold stall for a random count before each result
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(logic [1:0] r, int t, int v, logic [15:0] k);
    int n;
    n = draw_gap();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= r;
    sample_time <= t;
    sample_value <= v;
    query_index <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (LOAD_DRAIN) @(posedge clk);
  endtask

  // write all three registers back to back, block idle
  task automatic configure(int st, int unsigned stp, int unsigned cnt);
    logic [31:0] d [3];
    d[0] = st;
    d[1] = stp;
    d[2] = cnt;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1;
      cfg_index <= 2'(i);
      cfg_data <= d[i];
      sb.set_reg(2'(i), d[i]);
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  function automatic int rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  initial begin
    int base, t, span, incr, nsamp;
    int unsigned stp, k;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: too few samples, ignored code, out of range index
    send(REQ_QUERY, 0, 0, 0);
    for (int i = 0; i < 3; i++) send(REQ_LOAD, i * 65536, rand_value(), 0);
    send(REQ_QUERY, 0, 0, 16'hffff);
    send(2'd3, 32'hffffffff, 32'hffffffff, 16'hffff);
    send(REQ_LOAD, 3 * 65536, 32'sh7fffffff, 0);
    send(REQ_QUERY, 0, 0, 0);
    configure(32'sh80000000, 31'h7fffffff, 65535);
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 16'hffff);
    configure(0, 65536, 65535);
    send(REQ_LOAD, 4 * 65536, 32'sh80000000, 0);
    send(REQ_LOAD, 5 * 65536, 32'sh7fffffff, 0);
    send(REQ_QUERY, 0, 0, 1);
    // run ahead then back behind the cursor: no window
    send(REQ_QUERY, 0, 0, 3);
    send(REQ_QUERY, 0, 0, 1);
    // equal times inside the window
    send(REQ_CLEAR, 0, 0, 0);
    send(REQ_LOAD, 0, 100, 0);
    send(REQ_LOAD, 0, 200, 0);
    send(REQ_LOAD, 65536, 300, 0);
    send(REQ_LOAD, 131072, 400, 0);
    send(REQ_QUERY, 0, 0, 0);
    configure(32'sh7fffffff, 1, 1);
    send(REQ_QUERY, 0, 0, 0);

    // random phases: mostly ascending traces with queries walking forward
    for (int p = 0; p < 29; p++) begin
      nsamp = ($urandom_range(7) == 0) ? $urandom_range(5) : $urandom_range(4, 24);
      base = $signed($urandom) >>> 2;
      span = $urandom_range(1, 1 << 20);
      stp = $urandom_range(1, span);
      if ($urandom_range(9) == 0) stp = $urandom_range(1, 31'h7fffffff);
      configure(base - $signed($urandom_range(span)), stp,
                ($urandom_range(5) == 0) ? $urandom_range(65535) : 65535);
      send(REQ_CLEAR, 0, 0, 0);
      t = base;
      for (int i = 0; i < nsamp; i++) begin
        incr = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, span);
        if ($urandom_range(29) == 0) t = $urandom;
        else t += incr;
        send(REQ_LOAD, t, rand_value(), 0);
      end
      k = 0;
      for (int q = 0; q < 20; q++) begin
        case ($urandom_range(9))
          0: send(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom));
          1: send(REQ_QUERY, $urandom, $urandom, 16'($urandom));
          default: begin
            k += $urandom_range(3) * ((span / stp > 0) ? span / stp : 1) / 2 + 1;
            send(REQ_QUERY, $urandom, $urandom, k[15:0]);
          end
        endcase
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d loads and %0d queries (ok %0d, few %0d, range %0d, no window %0d)",
             sb.loads, sb.queries, sb.status_seen[ST_OK], sb.status_seen[ST_FEW],
             sb.status_seen[ST_RANGE], sb.status_seen[ST_NOWINDOW]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
